// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helper macros for the RTL files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge while not in reset.
`define ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// Implication with the consequent checked in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

// File: hw/rtl/ffha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;
	localparam int MAX_BLOCKS_DEF = 16;
	localparam int ADDR_W = 16;
	localparam int LEN_W = ADDR_W + 1;
	localparam logic [LEN_W-1:0] HEAP_RESET = LEN_W'(4096);

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_INIT  = 2'd2,
		ACT_BAD   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_NOFIT   = 3'd1,
		ST_FULL    = 3'd2,
		ST_NOADDR  = 3'd3,
		ST_ZERO    = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_A_SCAN,   // search free table for a fit
		S_A_USCAN,  // search used table for insert point
		S_A_USHIFT, // open a slot in the used table
		S_F_USCAN,  // search used table for the address
		S_F_PSCAN,  // search free table for insert point
		S_F_JOIN,   // evaluate neighbours
		S_F_FSHIFTU,// open a slot in the free table
		S_F_FSHIFTD,// close a slot in the free table
		S_USHIFTD,  // close a slot in the used table
		S_A_FSHIFTD,// remove an exactly fitted free entry
		S_DONE
	} state_t;
endpackage
`default_nettype wire

// File: hw/rtl/first_fit_heap_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a sorted free table and a sorted used table.
// ----------------------------------------------------------------------------
// channel  | signals                                      | dir
// request  | in_valid in_stall action request_size        | in
//          | release_address                              |
// result   | out_valid out_stall ok block_address status  | out
//          | freed_size                                   |
// config   | cfg_we cfg_wdata                             | in
// One item is worked through step by step before the next one is taken:
// each table scan and each entry shift walks one entry a cycle through the
// shared compare/add unit. Zero-size, bad-action and init requests go straight to S_DONE.
// in_stall is high from acceptance until the result is taken.
// Reset gives one free block of 4096 units; tables need no clearing pass.
// The result register holds its payload while out_stall is high.
module first_fit_heap_allocator #(
	parameter int MAX_BLOCKS = ffha_pkg::MAX_BLOCKS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [ffha_pkg::LEN_W-1:0]   cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [1:0]                   action,
	input  wire logic [ffha_pkg::LEN_W-1:0]   request_size,
	input  wire logic [ffha_pkg::ADDR_W-1:0]  release_address,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic                              ok,
	output logic [ffha_pkg::ADDR_W-1:0]       block_address,
	output logic [2:0]                        status,
	output logic [ffha_pkg::LEN_W-1:0]        freed_size
);
	import ffha_pkg::*;
	`include "assert_macros.svh"

	localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);
	localparam logic [LEN_W:0] LIMIT = (LEN_W+1)'(64'd1 << ADDR_W);

	// table storage
	logic [ADDR_W-1:0] fs_q [MAX_BLOCKS];
	logic [LEN_W-1:0]  fl_q [MAX_BLOCKS];
	logic [ADDR_W-1:0] us_q [MAX_BLOCKS];
	logic [LEN_W-1:0]  ul_q [MAX_BLOCKS];
	logic [CW-1:0] fcnt_q, ucnt_q;
	logic [LEN_W-1:0] heap_q;

	state_t state_q, state_d;
	logic [1:0] act_q;
	logic [LEN_W-1:0] size_q, len_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CW-1:0] i_q, f_q, u_q;
	logic jp_q;

	// a new request waits until the previous result is taken
	logic busy;
	logic in_xfer;
	assign busy = (state_q != S_IDLE);
	assign in_stall = busy || out_valid;
	assign in_xfer = in_valid && !in_stall;

	// shared unit: one entry read, one compare, one add
	logic [IW-1:0] ix;
	assign ix = i_q[IW-1:0];
	logic [ADDR_W-1:0] rd_fs, rd_us;
	logic [LEN_W-1:0] rd_fl, rd_ul;
	assign rd_fs = fs_q[ix];
	assign rd_fl = fl_q[ix];
	assign rd_us = us_q[ix];
	assign rd_ul = ul_q[ix];
	logic [ADDR_W:0] end_sum;
	assign end_sum = {1'b0, rd_fs} + rd_fl[ADDR_W:0];

	logic i_lt_f, i_lt_u;
	assign i_lt_f = i_q < fcnt_q;
	assign i_lt_u = i_q < ucnt_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (action)
						ACT_ALLOC: state_d = (request_size == '0) ? S_DONE : S_A_SCAN;
						ACT_FREE:  state_d = S_F_USCAN;
						default:   state_d = S_DONE;
					endcase
				end
			end
			S_A_SCAN: begin
				if (!i_lt_f) state_d = S_DONE;
				else if (rd_fl >= size_q) state_d = (ucnt_q >= CMAX) ? S_DONE : S_A_USCAN;
			end
			S_A_USCAN: begin
				if (!(i_lt_u && rd_us < addr_q)) state_d = S_A_USHIFT;
			end
			S_A_USHIFT: begin
				if (i_q == u_q) state_d = (len_q == size_q) ? S_A_FSHIFTD : S_DONE;
			end
			S_A_FSHIFTD: begin
				if (i_q + 1'b1 >= fcnt_q) state_d = S_DONE;
			end
			S_F_USCAN: begin
				if (!i_lt_u) state_d = S_DONE;
				else if (rd_us == addr_q) state_d = S_F_PSCAN;
			end
			S_F_PSCAN: begin
				if (!(i_lt_f && rd_fs < addr_q)) state_d = S_F_JOIN;
			end
			S_F_JOIN: begin
				state_d = S_F_JOIN;
			end
			S_F_FSHIFTU: begin
				if (i_q == f_q) state_d = S_USHIFTD;
			end
			S_F_FSHIFTD: begin
				if (i_q + 1'b1 >= fcnt_q) state_d = S_USHIFTD;
			end
			S_USHIFTD: begin
				if (i_q + 1'b1 >= ucnt_q) state_d = S_DONE;
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		// join decision reads prev, then next; with no prev entry only next is read
		if (state_q == S_F_JOIN && i_q == f_q) begin
			if (!jp_q && !(f_q < fcnt_q && {1'b0, addr_q} + len_q[ADDR_W:0]
				== {1'b0, rd_fs})) begin
				state_d = (fcnt_q >= CMAX) ? S_DONE : S_F_FSHIFTU;
			end else if (jp_q && f_q < fcnt_q && {1'b0, addr_q} + len_q[ADDR_W:0]
				== {1'b0, rd_fs}) begin
				state_d = S_F_FSHIFTD;
			end else begin
				state_d = S_USHIFTD;
			end
		end
	end

	logic jn_now;
	assign jn_now = (f_q < fcnt_q) &&
		({1'b0, addr_q} + len_q[ADDR_W:0] == {1'b0, rd_fs});

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fcnt_q <= CW'(1);
			ucnt_q <= '0;
			heap_q <= HEAP_RESET;
			out_valid <= 1'b0;
			fs_q[0] <= '0;
			fl_q[0] <= HEAP_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) heap_q <= cfg_wdata;
			// result valid rises after the last step and drops on its transfer
			if (state_q == S_DONE) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						act_q <= action;
						size_q <= request_size;
						addr_q <= release_address;
						i_q <= '0;
						ok <= 1'b0;
						block_address <= '0;
						freed_size <= '0;
						jp_q <= 1'b0;
						status <= ST_ZERO;
						if (action == ACT_INIT) begin
							ok <= 1'b1;
							status <= ST_OK;
							ucnt_q <= '0;
							if (heap_q == '0) fcnt_q <= '0;
							else begin
								fcnt_q <= CW'(1);
								fs_q[0] <= '0;
								fl_q[0] <= ({1'b0, heap_q} > LIMIT) ? LIMIT[LEN_W-1:0]
									: heap_q;
							end
						end
					end
				end
				S_A_SCAN: begin
					if (!i_lt_f) status <= ST_NOFIT;
					else if (rd_fl >= size_q) begin
						if (ucnt_q >= CMAX) status <= ST_FULL;
						else begin
							f_q <= i_q;
							addr_q <= rd_fs;
							len_q <= rd_fl;
							ok <= 1'b1;
							status <= ST_OK;
							block_address <= rd_fs;
							if (rd_fl > size_q) begin
								fs_q[ix] <= rd_fs + size_q[ADDR_W-1:0];
								fl_q[ix] <= rd_fl - size_q;
							end
							i_q <= '0;
						end
					end else i_q <= i_q + 1'b1;
				end
				S_A_USCAN: begin
					if (i_lt_u && rd_us < addr_q) i_q <= i_q + 1'b1;
					else begin
						u_q <= i_q;
						i_q <= ucnt_q;
					end
				end
				S_A_USHIFT: begin
					if (i_q == u_q) begin
						us_q[ix] <= addr_q;
						ul_q[ix] <= size_q;
						ucnt_q <= ucnt_q + 1'b1;
						i_q <= f_q;
					end else begin
						us_q[ix] <= us_q[IW'(i_q - 1'b1)];
						ul_q[ix] <= ul_q[IW'(i_q - 1'b1)];
						i_q <= i_q - 1'b1;
					end
				end
				S_A_FSHIFTD, S_F_FSHIFTD: begin
					if (i_q + 1'b1 >= fcnt_q) begin
						fcnt_q <= fcnt_q - 1'b1;
						i_q <= u_q;
					end else begin
						fs_q[ix] <= fs_q[IW'(i_q + 1'b1)];
						fl_q[ix] <= fl_q[IW'(i_q + 1'b1)];
						i_q <= i_q + 1'b1;
					end
				end
				S_F_USCAN: begin
					if (!i_lt_u) status <= ST_NOADDR;
					else if (rd_us == addr_q) begin
						u_q <= i_q;
						len_q <= rd_ul;
						i_q <= '0;
					end else i_q <= i_q + 1'b1;
				end
				S_F_PSCAN: begin
					if (i_lt_f && rd_fs < addr_q) i_q <= i_q + 1'b1;
					else begin
						f_q <= i_q;
						// look at the previous entry first
						i_q <= (i_q == '0) ? '0 : i_q - 1'b1;
						jp_q <= 1'b0;
					end
				end
				S_F_JOIN: begin
					if (i_q != f_q) begin
						jp_q <= (end_sum == {1'b0, addr_q});
						i_q <= f_q;
					end else begin
						if (!jp_q && !jn_now) begin
							if (fcnt_q >= CMAX) status <= ST_FULL;
							else i_q <= fcnt_q;
						end else if (jp_q && jn_now) begin
							fl_q[IW'(f_q - 1'b1)] <= fl_q[IW'(f_q - 1'b1)] + len_q + rd_fl;
							i_q <= f_q;
						end else if (jp_q) begin
							fl_q[IW'(f_q - 1'b1)] <= fl_q[IW'(f_q - 1'b1)] + len_q;
							i_q <= u_q;
						end else begin
							fs_q[ix] <= addr_q;
							fl_q[ix] <= rd_fl + len_q;
							i_q <= u_q;
						end
					end
				end
				S_F_FSHIFTU: begin
					if (i_q == f_q) begin
						fs_q[ix] <= addr_q;
						fl_q[ix] <= len_q;
						fcnt_q <= fcnt_q + 1'b1;
						i_q <= u_q;
					end else begin
						fs_q[ix] <= fs_q[IW'(i_q - 1'b1)];
						fl_q[ix] <= fl_q[IW'(i_q - 1'b1)];
						i_q <= i_q - 1'b1;
					end
				end
				S_USHIFTD: begin
					if (act_q == ACT_FREE) begin
						ok <= 1'b1;
						status <= ST_OK;
						freed_size <= len_q;
					end
					if (i_q + 1'b1 >= ucnt_q) begin
						if (act_q == ACT_FREE) ucnt_q <= ucnt_q - 1'b1;
					end else if (act_q == ACT_FREE) begin
						us_q[ix] <= us_q[IW'(i_q + 1'b1)];
						ul_q[ix] <= ul_q[IW'(i_q + 1'b1)];
						i_q <= i_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// table counts, result hold under stall, ok/status agreement
	`ASSERT_IMPL(a_cnt_range, clk, arst_n, 1'b1, fcnt_q <= CMAX && ucnt_q <= CMAX)
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status))
	`ASSERT_IMPL(a_ok_code, clk, arst_n, out_valid, ok == (status == ST_OK))
endmodule
`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate, free, init and invalid-action requests into the first-fit heap allocator
// and compares every result against a local model of both block tables.
// ----------------------------------------------------------------------------

import ffha_pkg::*;

// Expected-result store fed by a model of the free and used tables
class heap_scoreboard;
	localparam int NB = 16;
	logic [16:0] heap_units;
	logic [16:0] fr_start [NB];
	logic [16:0] fr_len [NB];
	int fr_cnt;
	logic [16:0] us_start [NB];
	logic [16:0] us_len [NB];
	int us_cnt;
	logic [36:0] pending [$];  // {ok, addr, status, freed}
	int errors;

	function new();
		heap_units = HEAP_RESET;
		errors = 0;
		init_tables();
	endfunction

	function void init_tables();
		logic [16:0] sz;
		sz = (heap_units > 17'd65536) ? 17'd65536 : heap_units;
		us_cnt = 0;
		if (sz == 0) fr_cnt = 0;
		else begin
			fr_start[0] = 0;
			fr_len[0] = sz;
			fr_cnt = 1;
		end
	endfunction

	function void push(logic okv, logic [15:0] a, status_t st, logic [16:0] fs);
		pending.push_back({okv, a, st, fs});
	endfunction

	function void do_alloc(logic [16:0] sz);
		int f, u;
		logic [16:0] a;
		f = -1;
		u = 0;
		if (sz == 0) begin
			push(0, 0, ST_ZERO, 0);
			return;
		end
		for (int i = 0; i < fr_cnt; i++)
			if (f < 0 && fr_len[i] >= sz) f = i;
		if (f < 0) begin
			push(0, 0, ST_NOFIT, 0);
			return;
		end
		if (us_cnt >= NB) begin
			push(0, 0, ST_FULL, 0);
			return;
		end
		a = fr_start[f];
		if (fr_len[f] > sz) begin
			fr_start[f] = (a + sz) & 17'hFFFF;
			fr_len[f] = fr_len[f] - sz;
		end else begin
			for (int i = f; i < fr_cnt - 1; i++) begin
				fr_start[i] = fr_start[i+1];
				fr_len[i] = fr_len[i+1];
			end
			fr_cnt--;
		end
		while (u < us_cnt && us_start[u] < a) u++;
		for (int i = us_cnt; i > u; i--) begin
			us_start[i] = us_start[i-1];
			us_len[i] = us_len[i-1];
		end
		us_start[u] = a;
		us_len[u] = sz;
		us_cnt++;
		push(1, a[15:0], ST_OK, 0);
	endfunction

	function void do_release(logic [15:0] a);
		int u, p;
		logic [16:0] st, ln;
		logic jp, jn;
		u = -1;
		p = 0;
		for (int i = 0; i < us_cnt; i++)
			if (u < 0 && us_start[i] == {1'b0, a}) u = i;
		if (u < 0) begin
			push(0, 0, ST_NOADDR, 0);
			return;
		end
		st = us_start[u];
		ln = us_len[u];
		while (p < fr_cnt && fr_start[p] < st) p++;
		jp = p > 0 && (18'(fr_start[p-1]) + fr_len[p-1] == 18'(st));
		jn = p < fr_cnt && (18'(st) + ln == 18'(fr_start[p]));
		if (!jp && !jn && fr_cnt >= NB) begin
			push(0, 0, ST_FULL, 0);
			return;
		end
		if (jp && jn) begin
			fr_len[p-1] = fr_len[p-1] + ln + fr_len[p];
			for (int i = p; i < fr_cnt - 1; i++) begin
				fr_start[i] = fr_start[i+1];
				fr_len[i] = fr_len[i+1];
			end
			fr_cnt--;
		end else if (jp) fr_len[p-1] = fr_len[p-1] + ln;
		else if (jn) begin
			fr_start[p] = st;
			fr_len[p] = fr_len[p] + ln;
		end else begin
			for (int i = fr_cnt; i > p; i--) begin
				fr_start[i] = fr_start[i-1];
				fr_len[i] = fr_len[i-1];
			end
			fr_start[p] = st;
			fr_len[p] = ln;
			fr_cnt++;
		end
		for (int i = u; i < us_cnt - 1; i++) begin
			us_start[i] = us_start[i+1];
			us_len[i] = us_len[i+1];
		end
		us_cnt--;
		push(1, 0, ST_OK, ln);
	endfunction

	// note one accepted request
	function void note_request(logic [1:0] act, logic [16:0] sz, logic [15:0] a);
		case (action_t'(act))
			ACT_ALLOC: do_alloc(sz);
			ACT_FREE: do_release(a);
			ACT_INIT: begin
				init_tables();
				push(1, 0, ST_OK, 0);
			end
			default: push(0, 0, ST_ZERO, 0);
		endcase
	endfunction

	// compare one accepted result with the oldest expectation
	function void check_result(logic okv, logic [15:0] a, logic [2:0] st, logic [16:0] fs);
		logic [36:0] e;
		if (pending.size() == 0) begin
			$display("%0t: unexpected result ok=%0d addr=%0d status=%0d freed=%0d",
				$time, okv, a, st, fs);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (e[36] !== okv) begin
			$display("%0t: ok expected %0d actual %0d", $time, e[36], okv);
			errors++;
		end
		if (e[35:20] !== a) begin
			$display("%0t: block_address expected %0d actual %0d", $time, e[35:20], a);
			errors++;
		end
		if (e[19:17] !== st) begin
			$display("%0t: status expected %0d actual %0d", $time, e[19:17], st);
			errors++;
		end
		if (e[16:0] !== fs) begin
			$display("%0t: freed_size expected %0d actual %0d", $time, e[16:0], fs);
			errors++;
		end
	endfunction
endclass

module testbench;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [16:0] cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [1:0] action;
	logic [16:0] request_size;
	logic [15:0] release_address;
	logic out_valid;
	logic out_stall;
	logic ok;
	logic [15:0] block_address;
	logic [2:0] status;
	logic [16:0] freed_size;

	heap_scoreboard sb;
	bit quiet;
	int idle_cycles;
	localparam int WATCHDOG = 5000;

	first_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .request_size(request_size),
		.release_address(release_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.ok(ok), .block_address(block_address), .status(status),
		.freed_size(freed_size)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// sample transfers at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_request(action, request_size, release_address);
			if (out_valid && !out_stall)
				sb.check_result(ok, block_address, status, freed_size);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	// result-side stall bursts
	initial begin
		out_stall = 0;
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1;
				repeat ($urandom_range(1, 8)) @(negedge clk);
				out_stall <= 0;
			end
		end
	end

	// valid stays up between back-to-back requests; it drops only for idling
	task automatic send(logic [1:0] act, logic [16:0] sz, logic [15:0] a);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_valid <= 1;
		action <= act;
		request_size <= sz;
		release_address <= a;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_heap(logic [16:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		sb.heap_units = v;
	endtask

	// free address: mostly a live block, sometimes anything
	function automatic logic [15:0] pick_addr();
		if (sb.us_cnt > 0 && $urandom_range(0, 9) != 0)
			return sb.us_start[$urandom_range(0, sb.us_cnt - 1)][15:0];
		return 16'($urandom);
	endfunction

	function automatic logic [16:0] pick_size(logic [16:0] heap);
		case ($urandom_range(0, 9))
			0: return 17'($urandom);
			1: return 0;
			default: return 17'($urandom_range(1, (heap / 8) + 1));
		endcase
	endfunction

	task automatic random_phase(int n, logic [16:0] heap);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 55) send(ACT_ALLOC, pick_size(heap), 16'($urandom));
			else if (r < 97) send(ACT_FREE, 17'($urandom), pick_addr());
			else if (r < 99) send(ACT_INIT, 17'($urandom), 16'($urandom));
			else send(ACT_BAD, 17'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		logic [16:0] heaps [6];
		sb = new();
		quiet = 0;
		idle_cycles = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		in_valid = 0;
		action = ACT_ALLOC;
		request_size = 0;
		release_address = 0;
		repeat (8) @(negedge clk);
		arst_n = 1;

		// directed: reset heap, extremes, every action and error
		send(ACT_ALLOC, 0, 16'hFFFF);
		send(ACT_ALLOC, 17'h1FFFF, 0);
		send(ACT_ALLOC, 4096, 0);
		send(ACT_FREE, 0, 0);
		send(ACT_FREE, 0, 16'hFFFF);
		send(ACT_BAD, 17'h1FFFF, 16'hFFFF);
		send(ACT_INIT, 0, 0);
		for (int i = 0; i < 17; i++) send(ACT_ALLOC, 1, 0);
		for (int i = 0; i < 16; i += 2) send(ACT_FREE, 0, 16'(i));
		send(ACT_FREE, 0, 16'd13);
		send(ACT_FREE, 0, 16'd1);
		set_heap(17'h1FFFF);
		send(ACT_INIT, 0, 0);
		send(ACT_ALLOC, 17'd65536, 0);
		send(ACT_FREE, 0, 0);
		set_heap(0);
		send(ACT_INIT, 0, 0);
		send(ACT_ALLOC, 1, 0);

		heaps = '{17'd1, 17'd65536, 17'd4096, 17'd200, 17'd65535, 17'd37};
		for (int k = 0; k < 6; k++) begin
			set_heap(heaps[k]);
			send(ACT_INIT, 0, 0);
			if (k == 5) quiet = 1;
			random_phase(235, heaps[k]);
		end

		drain();
		if (sb.errors == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end
endmodule
